/* sv/assert_macros.svh */
// Assertion macros for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk edge, disabled while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, written for a condition that must never hold.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* sv/bra_pkg.sv */
// Package for the bitmap run allocator: command and status codes, shared types.
`default_nettype none
package bra_pkg;

    typedef enum logic [2:0] {
        CMD_SCAN  = 3'd0,
        CMD_SET   = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_TEST  = 3'd3,
        CMD_ACQ   = 3'd4
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam int UNITS_PER_BYTE = 8;
    localparam logic [7:0] BYTE_FULL = 8'hFF;

    // Per-byte scan results
    typedef struct packed {
        logic [10:0] run_out;
        logic        found;
        logic [2:0]  pos;
        logic [3:0]  free_cnt;
        logic        any_free;
        logic [2:0]  low_free;
    } byte_scan_t;

endpackage
`default_nettype wire

/* sv/bra_byte_scan.sv */
// Per-byte free-run tracker, free-bit count and lowest free bit.
`default_nettype none
module bra_byte_scan (
    input  wire logic [7:0]          map_byte,
    input  wire logic [10:0]         run_in,
    input  wire logic [10:0]         count,
    output bra_pkg::byte_scan_t      res
);
    import bra_pkg::*;

    always_comb
    begin
        logic [10:0] run;
        logic        hit;
        logic [2:0]  pos;
        logic [3:0]  cnt;
        logic        any;
        logic [2:0]  low;
        run = run_in;
        hit = 1'b0;
        pos = 3'd0;
        cnt = 4'd0;
        any = 1'b0;
        low = 3'd0;
        for (int k = 0; k < UNITS_PER_BYTE; k++)
        begin
            if (!hit)
            begin
                run = map_byte[k] ? 11'd0 : run + 11'd1;
                if (run == count)
                begin
                    hit = 1'b1;
                    pos = 3'(k);
                end
            end
            if (!map_byte[k])
            begin
                cnt = cnt + 4'd1;
                if (!any)
                begin
                    low = 3'(k);
                end
                any = 1'b1;
            end
        end
        res.run_out  = run;
        res.found    = hit;
        res.pos      = pos;
        res.free_cnt = cnt;
        res.any_free = any;
        res.low_free = low;
    end

endmodule
`default_nettype wire

/* sv/bitmap_run_allocator.sv */
// Bitmap run allocator top level: map memory, command sequencer, result register.
`default_nettype none
`include "assert_macros.svh"
// The map lives in a byte-wide synchronous RAM (registered read data) that a
// sequencer reads, modifies and writes back; one request is worked at a time.
// After reset a clearing pass writes zero to all MAP_BYTES entries, one per
// cycle, while in_stall stays high. Set, clear and test read the byte, then
// write it back changed (test does not write) and offer the result. Scan walks
// the min(used_bytes, MAP_BYTES) bytes in use one per cycle. Acquire first counts
// free bits one byte per cycle, then walks again and hands out one bit per cycle
// unless the output is stalled. A result waits in an output register while the
// next request is accepted. used_bytes is written only while the block is idle.
module bitmap_run_allocator #(
    parameter int MAP_BYTES   = 128,
    parameter int MAX_ACQUIRE = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [2:0]  command,
    input  wire logic [9:0]  bit_index,
    input  wire logic [10:0] count,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic [9:0]  result_index,
    output      logic [1:0]  status,
    output      logic        is_taken,
    output      logic        last
);
    import bra_pkg::*;

    localparam int AW   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CAPB = (MAP_BYTES > 255) ? 255 : MAP_BYTES;
    localparam int EMW  = $clog2(MAX_ACQUIRE + 1);

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_RMW  = 8'b0000_0100,
        S_SCAN = 8'b0000_1000,
        S_ACQ1 = 8'b0001_0000,
        S_ACQ2 = 8'b0010_0000,
        S_EMIT = 8'b0100_0000
    } state_t;

    function automatic logic [AW-1:0] baddr(input logic [7:0] b);
        logic [AW+7:0] t;
        t = {{AW{1'b0}}, b};
        return t[AW-1:0];
    endfunction

    logic [7:0] mem [MAP_BYTES];
    logic [7:0] rdata_reg;
    logic          re, we;
    logic [AW-1:0] raddr, waddr;
    logic [7:0]    wdata;

    state_t state_reg, state_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [7:0]     used_reg;
    logic [7:0]     cb_reg, cb_next;
    logic [10:0]    run_reg, run_next;
    logic [10:0]    got_reg, got_next;
    logic [EMW-1:0] emit_reg, emit_next;
    logic           first_reg, first_next;
    logic [7:0]     wb_reg, wb_next;
    logic [2:0]     cmd_reg, cmd_next;
    logic [9:0]     bidx_reg, bidx_next;
    logic [10:0]    cnt_reg, cnt_next;
    logic [9:0]     pidx_reg, pidx_next;
    logic [1:0]     pst_reg, pst_next;
    logic           ptk_reg, ptk_next;
    logic           ov_reg, ov_next;
    logic [9:0]     oidx_reg, oidx_next;
    logic [1:0]     ost_reg, ost_next;
    logic           otk_reg, otk_next;
    logic           olast_reg, olast_next;

    logic [7:0]  eff;
    logic [10:0] nbits;
    logic        ofree;
    logic        last_byte;
    logic [7:0]  byte_in;
    logic [7:0]  cur;
    logic [11:0] got_sum;
    logic [10:0] start;
    logic [10:0] acq_idx;
    logic [7:0]  setb;
    byte_scan_t  bs;

    assign eff       = (used_reg > CAPB[7:0]) ? CAPB[7:0] : used_reg;
    assign nbits     = {eff, 3'b000};
    assign ofree     = !ov_reg || !out_stall;
    assign last_byte = (cb_reg == eff - 8'd1);
    assign cur       = first_reg ? rdata_reg : wb_reg;
    assign byte_in   = (state_reg == S_ACQ2) ? cur : rdata_reg;

    bra_byte_scan u_scan (
        .map_byte (byte_in),
        .run_in   (run_reg),
        .count    (cnt_reg),
        .res      (bs)
    );

    assign got_sum = {1'b0, got_reg} + {8'd0, bs.free_cnt};
    assign start   = {cb_reg, bs.pos} + 11'd1 - cnt_reg;
    assign acq_idx = {cb_reg, bs.low_free};
    assign setb    = cur | (8'h01 << bs.low_free);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cb_next    = cb_reg;
        run_next   = run_reg;
        got_next   = got_reg;
        emit_next  = emit_reg;
        first_next = first_reg;
        wb_next    = wb_reg;
        cmd_next   = cmd_reg;
        bidx_next  = bidx_reg;
        cnt_next   = cnt_reg;
        pidx_next  = pidx_reg;
        pst_next   = pst_reg;
        ptk_next   = ptk_reg;
        ov_next    = ov_reg && out_stall;
        oidx_next  = oidx_reg;
        ost_next   = ost_reg;
        otk_next   = otk_reg;
        olast_next = olast_reg;
        re    = 1'b0;
        raddr = baddr(cb_reg);
        we    = 1'b0;
        waddr = baddr(cb_reg);
        wdata = 8'h00;

        case (state_reg)
            S_CLR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(MAP_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = command;
                    bidx_next = bit_index;
                    cnt_next  = count;
                    cb_next   = 8'd0;
                    run_next  = 11'd0;
                    got_next  = 11'd0;
                    pidx_next = 10'd0;
                    ptk_next  = 1'b0;
                    pst_next  = ST_RANGE;
                    state_next = S_EMIT;
                    case (command)
                        CMD_SET, CMD_CLEAR, CMD_TEST:
                        begin
                            if ({1'b0, bit_index} < nbits)
                            begin
                                re         = 1'b1;
                                raddr      = baddr({1'b0, bit_index[9:3]});
                                state_next = S_RMW;
                            end
                        end
                        CMD_SCAN:
                        begin
                            if (count != 11'd0)
                            begin
                                if (eff == 8'd0)
                                begin
                                    pst_next = ST_NONE;
                                end
                                else
                                begin
                                    re         = 1'b1;
                                    raddr      = baddr(8'd0);
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        CMD_ACQ:
                        begin
                            if (count != 11'd0 && count <= 11'(MAX_ACQUIRE))
                            begin
                                if (eff == 8'd0)
                                begin
                                    pst_next = ST_NONE;
                                end
                                else
                                begin
                                    re         = 1'b1;
                                    raddr      = baddr(8'd0);
                                    state_next = S_ACQ1;
                                end
                            end
                        end
                        default:
                        begin
                            pst_next = ST_RANGE;
                        end
                    endcase
                end
            end
            S_RMW:
            begin
                pst_next = ST_OK;
                if (cmd_reg == CMD_TEST)
                begin
                    ptk_next = rdata_reg[bidx_reg[2:0]];
                end
                else
                begin
                    we    = 1'b1;
                    waddr = baddr({1'b0, bidx_reg[9:3]});
                    wdata = (cmd_reg == CMD_SET) ? (rdata_reg | (8'h01 << bidx_reg[2:0]))
                                                 : (rdata_reg & ~(8'h01 << bidx_reg[2:0]));
                end
                state_next = S_EMIT;
            end
            S_SCAN:
            begin
                if (bs.found)
                begin
                    pidx_next  = start[9:0];
                    pst_next   = ST_OK;
                    state_next = S_EMIT;
                end
                else if (last_byte)
                begin
                    pst_next   = ST_NONE;
                    state_next = S_EMIT;
                end
                else
                begin
                    re       = 1'b1;
                    raddr    = baddr(cb_reg + 8'd1);
                    cb_next  = cb_reg + 8'd1;
                    run_next = bs.run_out;
                end
            end
            S_ACQ1:
            begin
                if (got_sum >= {1'b0, cnt_reg})
                begin
                    // enough free bits: second walk hands them out
                    re         = 1'b1;
                    raddr      = baddr(8'd0);
                    cb_next    = 8'd0;
                    first_next = 1'b1;
                    emit_next  = '0;
                    state_next = S_ACQ2;
                end
                else if (last_byte)
                begin
                    pst_next   = ST_NONE;
                    state_next = S_EMIT;
                end
                else
                begin
                    re       = 1'b1;
                    raddr    = baddr(cb_reg + 8'd1);
                    cb_next  = cb_reg + 8'd1;
                    got_next = got_sum[10:0];
                end
            end
            S_ACQ2:
            begin
                if (!bs.any_free)
                begin
                    re         = 1'b1;
                    raddr      = baddr(cb_reg + 8'd1);
                    cb_next    = cb_reg + 8'd1;
                    first_next = 1'b1;
                end
                else if (ofree)
                begin
                    ov_next    = 1'b1;
                    oidx_next  = acq_idx[9:0];
                    ost_next   = ST_OK;
                    otk_next   = 1'b0;
                    olast_next = (11'(emit_reg) + 11'd1 == cnt_reg);
                    we         = 1'b1;
                    wdata      = setb;
                    wb_next    = setb;
                    first_next = 1'b0;
                    emit_next  = emit_reg + 1'b1;
                    if (11'(emit_reg) + 11'd1 == cnt_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                if (ofree)
                begin
                    ov_next    = 1'b1;
                    oidx_next  = pidx_reg;
                    ost_next   = pst_reg;
                    otk_next   = ptk_reg;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            used_reg  <= 8'd128;
            cb_reg    <= 8'd0;
            run_reg   <= 11'd0;
            got_reg   <= 11'd0;
            emit_reg  <= '0;
            first_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cb_reg    <= cb_next;
            run_reg   <= run_next;
            got_reg   <= got_next;
            emit_reg  <= emit_next;
            first_reg <= first_next;
            ov_reg    <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                used_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wb_reg    <= wb_next;
        cmd_reg   <= cmd_next;
        bidx_reg  <= bidx_next;
        cnt_reg   <= cnt_next;
        pidx_reg  <= pidx_next;
        pst_reg   <= pst_next;
        ptk_reg   <= ptk_next;
        oidx_reg  <= oidx_next;
        ost_reg   <= ost_next;
        otk_reg   <= otk_next;
        olast_reg <= olast_next;
    end

    // no register write while a request is worked or offered
    assign cfg_ready    = (state_reg == S_IDLE) && !in_valid;
    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = ov_reg;
    assign result_index = oidx_reg;
    assign status       = ost_reg;
    assign is_taken     = otk_reg;
    assign last         = olast_reg;

    `ASSERT_CLK(a_acq_within_count, (state_reg == S_ACQ2) |-> (11'(emit_reg) < cnt_reg), "acquire emitted past count")
    `ASSERT_NEVER(a_no_write_idle, (state_reg == S_IDLE) && we, "map write while idle")
    `ASSERT_CLK(a_accept_leaves_idle, (in_valid && !in_stall) |=> (state_reg != S_IDLE), "request accepted without work")

endmodule
`default_nettype wire

/* tb/sv/bitmap_run_allocator_tb.sv */
// Self-checking testbench for the bitmap run allocator: directed table, then random requests.
`default_nettype none
module bitmap_run_allocator_tb;
    import bra_pkg::*;

    localparam int MAP_BYTES   = 128;
    localparam int MAX_ACQUIRE = 64;
    localparam int IDLE_LIMIT  = 4000;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        logic [9:0] idx;
        logic [1:0] st;
        logic       tk;
        logic       lst;
    } alloc_res_t;

    typedef struct {
        logic [2:0]  c;
        logic [9:0]  bi;
        logic [10:0] cn;
        bit          typed;
        logic [1:0]  st;
        logic        tk;
    } req_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [9:0]  bit_index;
    logic [10:0] count;
    logic        out_valid;
    logic        out_stall;
    logic [9:0]  result_index;
    logic [1:0]  status;
    logic        is_taken;
    logic        last;

    bitmap_run_allocator #(
        .MAP_BYTES   (MAP_BYTES),
        .MAX_ACQUIRE (MAX_ACQUIRE)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .bit_index    (bit_index),
        .count        (count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_index (result_index),
        .status       (status),
        .is_taken     (is_taken),
        .last         (last)
    );

    // Predictor state
    bit         unit_map [0:MAP_BYTES*8-1];
    int         used_bytes_m;
    alloc_res_t pending_res [$];
    req_row_t   dir_tab [$];

    int  fail_cnt;
    int  idle_cycles;
    bit  quiet;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(negedge clk)
        out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 15);

    // Result checker
    always @(posedge clk)
    begin
        alloc_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_res.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_SHOWN)
                    $display("unexpected result idx=%0d st=%0d tk=%0b last=%0b",
                             result_index, status, is_taken, last);
            end
            else
            begin
                e = pending_res.pop_front();
                if (e.idx !== result_index || e.st !== status || e.tk !== is_taken
                    || e.lst !== last)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_SHOWN)
                        $display("mismatch exp idx=%0d st=%0d tk=%0b last=%0b, got idx=%0d st=%0d tk=%0b last=%0b",
                                 e.idx, e.st, e.tk, e.lst,
                                 result_index, status, is_taken, last);
                end
            end
        end
    end

    function automatic alloc_res_t mk_res(int idx, logic [1:0] st, logic tk, logic lst);
        alloc_res_t r;
        r.idx = idx[9:0];
        r.st  = st;
        r.tk  = tk;
        r.lst = lst;
        return r;
    endfunction

    function automatic int bits_in_use();
        return ((used_bytes_m > MAP_BYTES) ? MAP_BYTES : used_bytes_m) * 8;
    endfunction

    // Works out the results of one request and updates the map copy.
    task automatic predict_alloc(input logic [2:0] c, input logic [9:0] bi,
                                 input logic [10:0] cn);
        int n;
        int run;
        int found [$];
        n = bits_in_use();
        case (c)
            CMD_SET, CMD_CLEAR, CMD_TEST:
            begin
                if (bi >= n)
                    pending_res.push_back(mk_res(0, ST_RANGE, 1'b0, 1'b1));
                else if (c == CMD_TEST)
                    pending_res.push_back(mk_res(0, ST_OK, unit_map[bi], 1'b1));
                else
                begin
                    unit_map[bi] = (c == CMD_SET);
                    pending_res.push_back(mk_res(0, ST_OK, 1'b0, 1'b1));
                end
            end
            CMD_SCAN:
            begin
                if (cn == 0)
                    pending_res.push_back(mk_res(0, ST_RANGE, 1'b0, 1'b1));
                else
                begin
                    run = 0;
                    for (int i = 0; i < n; i++)
                    begin
                        run = unit_map[i] ? 0 : run + 1;
                        if (run == cn)
                        begin
                            pending_res.push_back(mk_res(i + 1 - cn, ST_OK, 1'b0, 1'b1));
                            return;
                        end
                    end
                    pending_res.push_back(mk_res(0, ST_NONE, 1'b0, 1'b1));
                end
            end
            CMD_ACQ:
            begin
                if (cn == 0 || cn > MAX_ACQUIRE)
                    pending_res.push_back(mk_res(0, ST_RANGE, 1'b0, 1'b1));
                else
                begin
                    for (int i = 0; i < n && found.size() < cn; i++)
                        if (!unit_map[i])
                            found.push_back(i);
                    if (found.size() < cn)
                        pending_res.push_back(mk_res(0, ST_NONE, 1'b0, 1'b1));
                    else
                        foreach (found[k])
                        begin
                            unit_map[found[k]] = 1'b1;
                            pending_res.push_back(mk_res(found[k], ST_OK, 1'b0,
                                                         k == cn - 1));
                        end
                end
            end
            default:
                pending_res.push_back(mk_res(0, ST_RANGE, 1'b0, 1'b1));
        endcase
    endtask

    // Called at a falling edge; returns at the rising edge that took the request.
    task automatic send_req(input req_row_t r);
        if (!quiet && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < 15);
        end
        in_valid  <= 1'b1;
        command   <= r.c;
        bit_index <= r.bi;
        count     <= r.cn;
        do
            @(posedge clk);
        while (in_stall);
        if (r.typed)
        begin
            predict_alloc(r.c, r.bi, r.cn);
            void'(pending_res.pop_back());
            pending_res.push_back(mk_res(0, r.st, r.tk, 1'b1));
        end
        else
            predict_alloc(r.c, r.bi, r.cn);
    endtask

    task automatic write_used(input logic [7:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        used_bytes_m = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_row_t rand_req();
        req_row_t r;
        int n;
        int pick;
        n = bits_in_use();
        pick = $urandom_range(0, 99);
        r.typed = 1'b0;
        r.st = ST_OK;
        r.tk = 1'b0;
        r.bi = 10'($urandom_range(0, n - 1));
        r.cn = 11'($urandom_range(1, 6));
        if (pick < 25)
            r.c = CMD_SET;
        else if (pick < 45)
            r.c = CMD_CLEAR;
        else if (pick < 60)
            r.c = CMD_TEST;
        else if (pick < 75)
            r.c = CMD_SCAN;
        else if (pick < 90)
        begin
            r.c = CMD_ACQ;
            if ($urandom_range(0, 9) == 0)
                r.cn = 11'($urandom_range(1, MAX_ACQUIRE));
        end
        else
        begin
            // noise: any command, any index, any count
            r.c  = 3'($urandom);
            r.bi = 10'($urandom);
            r.cn = 11'($urandom);
        end
        return r;
    endfunction

    task automatic random_phase(input int items);
        for (int i = 0; i < items; i++)
        begin
            @(negedge clk);
            quiet = (i >= items / 2 && i < items / 2 + 15);
            send_req(rand_req());
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        command   = '0;
        bit_index = '0;
        count     = '0;
        out_stall = 1'b0;
        quiet     = 1'b0;
        fail_cnt  = 0;
        idle_cycles = 0;
        used_bytes_m = 128;
        foreach (unit_map[i])
            unit_map[i] = 1'b0;

        // c, index, count, typed, status, taken
        dir_tab.push_back('{CMD_TEST,  10'd0,    11'd1,    1, ST_OK,    1'b0});
        dir_tab.push_back('{CMD_TEST,  10'd1023, 11'd1,    1, ST_OK,    1'b0});
        dir_tab.push_back('{CMD_SET,   10'd1023, 11'd1,    1, ST_OK,    1'b0});
        dir_tab.push_back('{CMD_TEST,  10'd1023, 11'd1,    1, ST_OK,    1'b1});
        dir_tab.push_back('{CMD_SCAN,  10'd0,    11'd0,    1, ST_RANGE, 1'b0});
        dir_tab.push_back('{CMD_ACQ,   10'd0,    11'd0,    1, ST_RANGE, 1'b0});
        dir_tab.push_back('{CMD_ACQ,   10'd0,    11'd65,   1, ST_RANGE, 1'b0});
        dir_tab.push_back('{CMD_ACQ,   10'd0,    11'd2047, 1, ST_RANGE, 1'b0});
        dir_tab.push_back('{CMD_SCAN,  10'd0,    11'd2047, 1, ST_NONE,  1'b0});
        dir_tab.push_back('{CMD_SCAN,  10'd0,    11'd1024, 1, ST_NONE,  1'b0});
        dir_tab.push_back('{CMD_SCAN,  10'd0,    11'd1023, 0, ST_OK,    1'b0});
        dir_tab.push_back('{CMD_ACQ,   10'd0,    11'd64,   0, ST_OK,    1'b0});
        dir_tab.push_back('{CMD_ACQ,   10'd0,    11'd1,    0, ST_OK,    1'b0});
        dir_tab.push_back('{CMD_SCAN,  10'd0,    11'd1,    0, ST_OK,    1'b0});
        dir_tab.push_back('{CMD_SCAN,  10'd0,    11'd958,  0, ST_OK,    1'b0});
        dir_tab.push_back('{3'd5,      10'd0,    11'd1,    1, ST_RANGE, 1'b0});
        dir_tab.push_back('{3'd6,      10'd1023, 11'd2047, 1, ST_RANGE, 1'b0});
        dir_tab.push_back('{3'd7,      10'd5,    11'd3,    1, ST_RANGE, 1'b0});
        dir_tab.push_back('{CMD_CLEAR, 10'd1023, 11'd1,    1, ST_OK,    1'b0});
        dir_tab.push_back('{CMD_CLEAR, 10'd3,    11'd1,    1, ST_OK,    1'b0});
        dir_tab.push_back('{CMD_ACQ,   10'd0,    11'd2,    0, ST_OK,    1'b0});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
        begin
            @(negedge clk);
            send_req(dir_tab[i]);
        end

        // smallest map: bits 0..7 all taken by now
        write_used(8'd1);
        @(negedge clk);
        send_req('{CMD_SET, 10'd8, 11'd1, 1, ST_RANGE, 1'b0});
        @(negedge clk);
        send_req('{CMD_ACQ, 10'd0, 11'd1, 1, ST_NONE, 1'b0});
        @(negedge clk);
        send_req('{CMD_TEST, 10'd7, 11'd1, 1, ST_OK, 1'b1});
        random_phase(40);

        write_used(8'd128);
        random_phase(60);
        write_used(8'd4);
        random_phase(40);
        write_used(8'($urandom_range(1, 128)));
        random_phase(40);
        write_used(8'd128);
        random_phase(50);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);

        if (fail_cnt == 0 && pending_res.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

/* bitmap_run_allocator.f */
+incdir+sv
sv/bra_pkg.sv
sv/bra_byte_scan.sv
sv/bitmap_run_allocator.sv
tb/sv/bitmap_run_allocator_tb.sv
